>>> rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the signed frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Parser phase, one-hot coded.
  typedef enum logic [12:0] {
    PH_MAGIC = 13'b0_0000_0000_0001,
    PH_TYPE  = 13'b0_0000_0000_0010,
    PH_NONCE = 13'b0_0000_0000_0100,
    PH_KEY   = 13'b0_0000_0000_1000,
    PH_ADDR  = 13'b0_0000_0001_0000,
    PH_VLEN  = 13'b0_0000_0010_0000,
    PH_VER   = 13'b0_0000_0100_0000,
    PH_ALEN  = 13'b0_0000_1000_0000,
    PH_ACCT  = 13'b0_0001_0000_0000,
    PH_PLEN  = 13'b0_0010_0000_0000,
    PH_PAY   = 13'b0_0100_0000_0000,
    PH_SIG   = 13'b0_1000_0000_0000,
    PH_TRAIL = 13'b1_0000_0000_0000
  } phase_t;

  // Field codes as reported on the result channel.
  localparam logic [3:0] FC_MAGIC = 4'd0;
  localparam logic [3:0] FC_TYPE  = 4'd1;
  localparam logic [3:0] FC_NONCE = 4'd2;
  localparam logic [3:0] FC_KEY   = 4'd3;
  localparam logic [3:0] FC_ADDR  = 4'd4;
  localparam logic [3:0] FC_VLEN  = 4'd5;
  localparam logic [3:0] FC_VER   = 4'd6;
  localparam logic [3:0] FC_ALEN  = 4'd7;
  localparam logic [3:0] FC_ACCT  = 4'd8;
  localparam logic [3:0] FC_PLEN  = 4'd9;
  localparam logic [3:0] FC_PAY   = 4'd10;
  localparam logic [3:0] FC_SIG   = 4'd11;
  localparam logic [3:0] FC_TRAIL = 4'd12;

  // Frame status codes; the error codes share the same values.
  localparam logic [2:0] ST_PROGRESS = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_BADMAGIC = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_OVERCAP  = 3'd4;

  // Fixed field lengths in bytes.
  localparam logic [15:0] MAGIC_LEN = 16'd4;
  localparam logic [15:0] TYPE_LEN  = 16'd1;
  localparam logic [15:0] NONCE_LEN = 16'd16;
  localparam logic [15:0] KEY_LEN   = 16'd32;
  localparam logic [15:0] ADDR_LEN  = 16'd16;
  localparam logic [15:0] SIG_LEN   = 16'd64;

  // Configuration register indexes.
  localparam logic CFG_MAGIC    = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  // Per-frame parser state.
  typedef struct packed {
    phase_t      phase;
    logic [15:0] cnt;
    logic [15:0] decl;
    logic [2:0]  err;
  } parse_state_t;

  // One tagged result item.
  typedef struct packed {
    logic [2:0]  status;
    logic        sgn;
    logic [15:0] offset;
    logic [3:0]  code;
    logic [7:0]  data;
  } result_t;

  // Map a phase to its reported field code.
  function automatic logic [3:0] phase_code(input phase_t ph);
    logic [3:0] c;
    case (ph)
      PH_MAGIC: c = FC_MAGIC;
      PH_TYPE:  c = FC_TYPE;
      PH_NONCE: c = FC_NONCE;
      PH_KEY:   c = FC_KEY;
      PH_ADDR:  c = FC_ADDR;
      PH_VLEN:  c = FC_VLEN;
      PH_VER:   c = FC_VER;
      PH_ALEN:  c = FC_ALEN;
      PH_ACCT:  c = FC_ACCT;
      PH_PLEN:  c = FC_PLEN;
      PH_PAY:   c = FC_PAY;
      PH_SIG:   c = FC_SIG;
      default:  c = FC_TRAIL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/signed_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// signed_frame_deframer_core
// Byte-wise deframer that tags each byte with its field and offset and
// reports the framing status on the last byte of a frame.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while the output is not stalled and
// presents one tagged result per byte: an accepted byte is held in the input
// register, and its result moves into the output register once that register
// is free. The parser state lives in a single register set that is updated by
// one step of combinational logic between the input register and the output
// register, so consecutive bytes of a frame follow each other without gaps.
// The output register and the input register together let a new byte be taken
// while a finished result still waits to be read. Configuration writes are
// always ready and should only be made while no frame is in flight.
// ----------------------------------------------------------------------------
module signed_frame_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input bytes.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Tagged results.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_byte, [11:8] field_code, [27:12] field_offset,
  // [28] in_signed_region, [31:29] frame_status
  output logic [31:0] out_tdata,
  output logic        out_tlast,  // frame_done
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_last_r;
  logic [31:0] magic_r;
  logic [15:0] cap_r;
  logic        adv;
  logic        in_acc;

  sfd_pkg::parse_state_t state_r;
  sfd_pkg::parse_state_t state_nxt;
  sfd_pkg::result_t      res;

  // Handshake: stage one moves on when the output register is free.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Parser step.
  sfd_parse u_parse (
    .st               (state_r),
    .data_byte        (s1_byte_r),
    .last_byte        (s1_last_r),
    .magic_word       (magic_r),
    .payload_capacity (cap_r),
    .st_nxt           (state_nxt),
    .res              (res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= 32'd0;
      cap_r   <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfd_pkg::CFG_MAGIC:    magic_r <= cfg_data;
        sfd_pkg::CFG_CAPACITY: cap_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Control state: valid flags and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r.phase <= sfd_pkg::PH_MAGIC;
      state_r.cnt   <= 16'd0;
      state_r.decl  <= 16'd0;
      state_r.err   <= sfd_pkg::ST_PROGRESS;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (adv) begin
      out_data_r <= res;
      out_last_r <= s1_last_r;
    end
  end

endmodule

>>> rtl/core/sfd_parse.sv
// ----------------------------------------------------------------------------
// sfd_parse
// Combinational step of the frame parser: tags one byte and computes the
// parser state that follows it.
// ----------------------------------------------------------------------------
module sfd_parse (
  input  sfd_pkg::parse_state_t st,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [31:0]           magic_word,
  input  logic [15:0]           payload_capacity,
  output sfd_pkg::parse_state_t st_nxt,
  output sfd_pkg::result_t      res
);

  logic [15:0] cnt_inc;
  logic [1:0]  magic_sel;
  logic [7:0]  magic_want;
  logic [15:0] plen_full;
  sfd_pkg::parse_state_t upd;

  assign cnt_inc    = st.cnt + 16'd1;
  assign magic_sel  = 2'd3 - st.cnt[1:0];
  assign magic_want = 8'(magic_word >> {magic_sel, 3'b000});
  assign plen_full  = st.decl | {8'h00, data_byte};

  // Tag the byte and advance the phase.
  always_comb begin
    upd        = st;
    res.data   = data_byte;
    res.code   = sfd_pkg::phase_code(st.phase);
    res.offset = st.cnt;
    res.sgn    = (st.phase != sfd_pkg::PH_MAGIC) && (st.phase != sfd_pkg::PH_SIG) &&
                 (st.phase != sfd_pkg::PH_TRAIL);
    res.status = sfd_pkg::ST_PROGRESS;

    if (st.err != sfd_pkg::ST_PROGRESS) begin
      // Discarding the rest of a failed frame.
      res.code   = sfd_pkg::FC_TRAIL;
      res.offset = 16'd0;
      res.sgn    = 1'b0;
    end else begin
      case (st.phase)
        sfd_pkg::PH_MAGIC: begin
          if (data_byte != magic_want) begin
            upd.err = sfd_pkg::ST_BADMAGIC;
          end else if (cnt_inc >= sfd_pkg::MAGIC_LEN) begin
            upd.phase = sfd_pkg::PH_TYPE;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_TYPE: begin
          if (cnt_inc >= sfd_pkg::TYPE_LEN) begin
            upd.phase = sfd_pkg::PH_NONCE;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_NONCE: begin
          if (cnt_inc >= sfd_pkg::NONCE_LEN) begin
            upd.phase = sfd_pkg::PH_KEY;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_KEY: begin
          if (cnt_inc >= sfd_pkg::KEY_LEN) begin
            upd.phase = sfd_pkg::PH_ADDR;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_ADDR: begin
          if (cnt_inc >= sfd_pkg::ADDR_LEN) begin
            upd.phase = sfd_pkg::PH_VLEN;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_VLEN: begin
          upd.decl  = {8'h00, data_byte};
          upd.cnt   = 16'd0;
          upd.phase = (data_byte != 8'd0) ? sfd_pkg::PH_VER : sfd_pkg::PH_ALEN;
        end
        sfd_pkg::PH_VER: begin
          if (cnt_inc >= st.decl) begin
            upd.phase = sfd_pkg::PH_ALEN;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_ALEN: begin
          upd.decl  = {8'h00, data_byte};
          upd.cnt   = 16'd0;
          upd.phase = (data_byte != 8'd0) ? sfd_pkg::PH_ACCT : sfd_pkg::PH_PLEN;
        end
        sfd_pkg::PH_ACCT: begin
          if (cnt_inc >= st.decl) begin
            upd.phase = sfd_pkg::PH_PLEN;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_PLEN: begin
          if (st.cnt == 16'd0) begin
            // High byte of the big-endian payload length.
            upd.decl = {data_byte, 8'h00};
            upd.cnt  = 16'd1;
          end else begin
            upd.decl = plen_full;
            if ((payload_capacity != 16'd0) && (plen_full > payload_capacity)) begin
              upd.err = sfd_pkg::ST_OVERCAP;
            end else begin
              upd.phase = (plen_full != 16'd0) ? sfd_pkg::PH_PAY : sfd_pkg::PH_SIG;
              upd.cnt   = 16'd0;
            end
          end
        end
        sfd_pkg::PH_PAY: begin
          if (cnt_inc >= st.decl) begin
            upd.phase = sfd_pkg::PH_SIG;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        sfd_pkg::PH_SIG: begin
          if (cnt_inc >= sfd_pkg::SIG_LEN) begin
            upd.phase = sfd_pkg::PH_TRAIL;
            upd.cnt   = 16'd0;
          end else begin
            upd.cnt = cnt_inc;
          end
        end
        default: begin
          // Trailing bytes; the offset saturates.
          upd.phase = sfd_pkg::PH_TRAIL;
          if (st.cnt != 16'hFFFF) begin
            upd.cnt = cnt_inc;
          end
        end
      endcase
    end

    // End of frame: report status and start over.
    st_nxt = upd;
    if (last_byte) begin
      if (upd.err != sfd_pkg::ST_PROGRESS) begin
        res.status = upd.err;
      end else if (upd.phase == sfd_pkg::PH_TRAIL) begin
        res.status = sfd_pkg::ST_ACCEPT;
      end else begin
        res.status = sfd_pkg::ST_TRUNC;
      end
      st_nxt.phase = sfd_pkg::PH_MAGIC;
      st_nxt.cnt   = 16'd0;
      st_nxt.decl  = 16'd0;
      st_nxt.err   = sfd_pkg::ST_PROGRESS;
    end
  end

endmodule

>>> rtl/core/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level assertions for the signed frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Status is reported only on the last byte of a frame.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[31:29] == sfd_pkg::ST_PROGRESS)
    else $error("status outside end of frame");

  // A frame end always carries a nonzero status.
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[31:29] != sfd_pkg::ST_PROGRESS &&
      out_tdata[31:29] <= sfd_pkg::ST_OVERCAP)
    else $error("bad status at end of frame");

  // The signed-region mark follows the field code.
  a_signed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[28] == (out_tdata[11:8] >= sfd_pkg::FC_TYPE &&
      out_tdata[11:8] <= sfd_pkg::FC_PAY))
    else $error("signed-region mark mismatch");

  // A magic byte never carries an offset past the end of the magic field.
  a_magic_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11:8] == sfd_pkg::FC_MAGIC |->
      out_tdata[27:12] < sfd_pkg::MAGIC_LEN)
    else $error("magic offset out of range");

endmodule

bind signed_frame_deframer_core sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
